// File: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// Delimiter stream splitter package
// Shared types, register indexes and helpers for the splitter and its cells.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int BYTE_W     = 8;
    localparam int PAT_BYTES  = 8;
    localparam int CFG_DATA_W = PAT_BYTES * BYTE_W;
    localparam int LEN_W      = 4;

    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [CFG_DATA_W-1:0] t_pat;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [0:0]            t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx REG_DELIM_BYTES = 1'b0;
    localparam t_cfg_idx REG_DELIM_LEN   = 1'b1;

    // One result beat.
    typedef struct packed {
        t_byte out_byte;
        logic  piece_end;
        logic  string_end;
    } t_res;

    typedef enum logic [1:0] {
        S_RUN,
        S_TRIM,
        S_FLUSH
    } t_state;

    // Byte i of the delimiter pattern, first byte in bits 7:0.
    function automatic t_byte pat_byte(input t_pat pat, input logic [2:0] idx);
        pat_byte = pat[{idx, 3'b000} +: BYTE_W];
    endfunction

endpackage

// File: rtl/dss_in_if.sv
// ----------------------------------------------------------------------------
// Splitter input channel
// Valid/ready channel carrying one string byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface dss_in_if;
    import dss_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// File: rtl/dss_out_if.sv
// ----------------------------------------------------------------------------
// Splitter output channel
// Valid/ready channel carrying one piece byte with its end markers.
// ----------------------------------------------------------------------------
interface dss_out_if;
    import dss_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  piece_end;
    logic  string_end;

    modport source (output valid, output out_byte, output piece_end, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input piece_end, input string_end,
                    output ready);
endinterface

// File: rtl/dss_cell.sv
// ----------------------------------------------------------------------------
// Splitter window cell
// Holds one byte of the hold window, passes it to the next cell on a shift
// and compares the byte it would hold against its expected pattern byte.
// ----------------------------------------------------------------------------
module dss_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  dss_pkg::t_byte i_byte,
    input  dss_pkg::t_byte i_exp,
    output dss_pkg::t_byte o_q,
    output dss_pkg::t_byte o_view,
    output logic          o_hit
);
    import dss_pkg::*;

    t_byte r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_byte;
        end
    end

    // The view is the content this cell holds once the current beat is in.
    assign o_view = i_shift ? i_byte : r_q;
    assign o_hit  = (o_view == i_exp);
    assign o_q    = r_q;

endmodule

// File: rtl/dss_obuf.sv
// ----------------------------------------------------------------------------
// Splitter output buffer
// Two-entry result buffer that drives the output channel and lets the core
// keep working while one finished beat waits for the receiver.
// ----------------------------------------------------------------------------
module dss_obuf (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  dss_pkg::t_res i_res,
    output logic         o_full,
    dss_out_if.source    o_out
);
    import dss_pkg::*;

    t_res       r_ent [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_pop;
    logic       w_wpos;

    assign w_pop  = (r_cnt != 2'd0) && o_out.ready;
    assign w_wpos = (r_cnt == 2'd2) || ((r_cnt == 2'd1) && !w_pop);
    assign n_cnt  = r_cnt + {1'b0, i_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // A new beat written to the head takes precedence over the shift.
    always_ff @(posedge i_clk) begin
        if (i_push && !w_wpos) begin
            r_ent[0] <= i_res;
        end else if (w_pop) begin
            r_ent[0] <= r_ent[1];
        end
        if (i_push && w_wpos) begin
            r_ent[1] <= i_res;
        end
    end

    assign o_full           = (r_cnt == 2'd2);
    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.out_byte   = r_ent[0].out_byte;
    assign o_out.piece_end  = r_ent[0].piece_end;
    assign o_out.string_end = r_ent[0].string_end;

endmodule

// File: rtl/delimiter_stream_splitter_core.sv
// ----------------------------------------------------------------------------
// Delimiter stream splitter
// Cuts a byte stream into pieces at a configured delimiter of 1 to 8 bytes.
// ----------------------------------------------------------------------------
// Usage: string bytes enter on i_in, one beat per byte, is_last on the final
// byte. Bytes leave on o_out with splitting delimiters removed; piece_end marks
// the last byte of each piece, string_end the last byte of the string.
// The delimiter pattern and length are written on the i_cfg_* port while the
// block is idle. Within a string the block takes one byte per cycle while the
// output buffer has room and no trim or flush runs. A byte is held in the row
// of window cells until L further bytes have arrived (L is the delimiter
// length), then leaves through the two-entry output buffer. On the last byte
// of a string the held bytes are flushed, one per cycle while the buffer has
// room, stalling i_in until the window is empty; after a shortened delimiter
// length the next beat first trims the surplus held bytes. The buffer takes a
// new result while an earlier one still waits, so a receiver stall reaches i_in
// only once both entries are full. Reset is synchronous: it empties the window
// and the output buffer and sets the delimiter to one zero byte.
// ----------------------------------------------------------------------------
module delimiter_stream_splitter_core #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  dss_pkg::t_cfg_idx    i_cfg_idx,
    input  dss_pkg::t_pat        i_cfg_data,
    dss_in_if.sink               i_in,
    dss_out_if.source            o_out
);
    import dss_pkg::*;

    localparam int WIN = MAX_DELIM_BYTES + 1;
    localparam int CW  = $clog2(MAX_DELIM_BYTES + 2);
    localparam int IW  = $clog2(WIN);

    // Configuration.
    t_pat   r_delim;
    t_len   r_len;

    // Control state.
    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_stopped;
    logic          n_stopped;
    logic          r_last;
    logic          n_last;

    logic          w_accept;
    logic          w_ofull;
    logic          w_emit;
    t_res          w_res;
    logic [CW-1:0] w_len;
    logic [CW-1:0] w_lenp1;
    logic [CW-1:0] w_c;
    logic [CW-1:0] w_cm1;
    logic          w_lastv;
    logic          w_all;
    t_byte         w_old;

    t_byte         w_q    [WIN];
    t_byte         w_view [WIN];
    logic [WIN-1:0] w_hit;
    logic [WIN-1:0] w_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= '0;
            r_len   <= t_len'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DELIM_BYTES: r_delim <= i_cfg_data;
                REG_DELIM_LEN:   r_len   <= i_cfg_data[LEN_W-1:0];
                default:         r_delim <= r_delim;
            endcase
        end
    end

    // Effective length: zero acts as one, values above MAX_DELIM_BYTES as the maximum.
    always_comb begin
        if (r_len == '0) begin
            w_len = CW'(1);
        end else if (r_len > t_len'(MAX_DELIM_BYTES)) begin
            w_len = CW'(MAX_DELIM_BYTES);
        end else begin
            w_len = CW'(r_len);
        end
    end
    assign w_lenp1 = w_len + CW'(1);

    assign i_in.ready = (r_state == S_RUN) && !w_ofull;
    assign w_accept   = i_in.valid && i_in.ready;

    // Cell 0 holds the newest byte; the oldest held byte sits in cell count-1.
    for (genvar k = 0; k < WIN; k++) begin : g_cell
        t_byte w_exp;
        t_byte w_in;

        assign w_use[k] = (CW'(k) < w_len);
        assign w_exp    = pat_byte(r_delim, 3'(w_len - CW'(1) - CW'(k)));

        if (k == 0) begin : g_head
            assign w_in = i_in.in_byte;
        end else begin : g_body
            assign w_in = w_q[k-1];
        end

        dss_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_accept),
            .i_byte (w_in),
            .i_exp  (w_exp),
            .o_q    (w_q[k]),
            .o_view (w_view[k]),
            .o_hit  (w_hit[k])
        );
    end

    assign w_c     = w_accept ? r_cnt + CW'(1) : r_cnt;
    assign w_cm1   = w_c - CW'(1);
    assign w_lastv = w_accept ? i_in.is_last : r_last;
    assign w_all   = &(w_hit | ~w_use);
    assign w_old   = w_view[w_cm1[IW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_cnt     <= '0;
            r_stopped <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
            r_last    <= n_last;
        end
    end

    always_comb begin
        logic v_eval;
        logic v_match;

        v_eval    = 1'b0;
        v_match   = !r_stopped && (w_c >= w_len) && w_all;
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_stopped = r_stopped;
        n_last    = r_last;
        w_emit    = 1'b0;
        w_res     = '{out_byte: w_old, piece_end: 1'b0, string_end: 1'b0};

        unique case (r_state)
            S_RUN: begin
                if (w_accept) begin
                    if (w_c > w_lenp1) begin
                        // Window longer than the new delimiter allows: trim first.
                        n_state = S_TRIM;
                        n_cnt   = w_c;
                        n_last  = w_lastv;
                    end else begin
                        v_eval = 1'b1;
                    end
                end
            end
            S_TRIM: begin
                if (!w_ofull) begin
                    if (w_c > w_lenp1) begin
                        w_emit = 1'b1;
                        n_cnt  = w_cm1;
                    end else begin
                        v_eval = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!w_ofull) begin
                    w_emit           = 1'b1;
                    w_res.piece_end  = (w_c == CW'(1));
                    w_res.string_end = (w_c == CW'(1));
                    n_cnt            = w_cm1;
                    if (w_c == CW'(1)) begin
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        if (v_eval) begin
            n_state = S_RUN;
            if (v_match && (w_c != w_len) && !w_lastv) begin
                // Split: the byte before the delimiter closes the piece.
                w_emit          = 1'b1;
                w_res.piece_end = 1'b1;
                n_cnt           = '0;
            end else if (w_lastv) begin
                w_emit           = 1'b1;
                w_res.piece_end  = (w_c == CW'(1));
                w_res.string_end = (w_c == CW'(1));
                n_cnt            = w_cm1;
                n_stopped        = 1'b0;
                if (w_c != CW'(1)) begin
                    n_state = S_FLUSH;
                end
            end else begin
                n_stopped = r_stopped || v_match;
                if (w_c > w_len) begin
                    w_emit = 1'b1;
                    n_cnt  = w_cm1;
                end else begin
                    n_cnt = w_c;
                end
            end
        end
    end

    dss_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_emit),
        .i_res  (w_res),
        .o_full (w_ofull),
        .o_out  (o_out)
    );

`ifndef SYNTH
    // A result is only produced when the output buffer has room.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> !w_ofull)
        else $error("result produced while output buffer full");

    // The end of a flush leaves an empty window and splitting enabled.
    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && n_state == S_RUN) |=> (r_cnt == '0 && !r_stopped))
        else $error("flush ended with bytes held or splitting stopped");

    // The window never holds more bytes than it has cells.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WIN))
        else $error("hold count beyond window size");

    // A string end on the output always closes a piece as well.
    a_end_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_res.string_end) |-> w_res.piece_end)
        else $error("string end without piece end");
`endif

endmodule
